@@ design/fgc_pkg.sv @@
// Package for the filtered group counter.
// Holds the shared widths, item codes and the counter store write control type.
// No dependencies.
`default_nettype none

package fgc_pkg;

    localparam int GROUPS         = 256;
    localparam int GROUP_BITS     = 8;
    localparam int FLAG_BITS      = 8;
    localparam int OUT_BITS       = 40;
    localparam int MASK_WORDS     = 4;
    localparam int MASK_BITS      = 64;
    localparam int MASK_IDX_BITS  = 6;
    localparam int CFG_INDEX_BITS = 2;

    // Flag bits that must both be set for a row to count
    localparam logic [1:0] PASS_BITS = 2'b11;
    localparam int         PRIO_BIT  = 2;

    // Item function codes
    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic                  en;
        logic [GROUP_BITS-1:0] addr;
    } wr_ctl_t;

endpackage : fgc_pkg

`default_nettype wire

@@ design/filtered_group_count.sv @@
// Top level of the filtered group counter: mask registers, pipeline control, output register.
// Depends on fgc_pkg and fgc_count_ram.
`default_nettype none

// Group-by counting engine for a database scan. A row item (func 0) counts when its
// group is selected in the 256-bit mask (four 64-bit registers, index 0 for groups
// 0..63) and flag bits 0 and 1 are set; flag bit 2 picks the high or low counter,
// which saturates at 2^COUNT_BITS-1. A read item (func 1) returns both counts of a
// group, clipped to 40 bits. The block takes one item per cycle while the output is not
// stalled: an item is looked up in the counter memory at acceptance; in the next cycle
// it is filtered and incremented, and the write-back and the load of its result into the
// output register happen at the same edge, which raises out_valid. The single read and
// single write port of the counter memory set that rate; a write-back to the group read
// in the same cycle is forwarded. A stalled output register holds the lookup stage and
// then the input. Counters read as zero after reset through per-group valid bits, so no
// clearing pass is needed and items are taken right after reset.
module filtered_group_count #(
    parameter int COUNT_BITS = 40
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [fgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [fgc_pkg::MASK_BITS-1:0]      cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              func,
    input  wire logic [fgc_pkg::GROUP_BITS-1:0]     group_code,
    input  wire logic [fgc_pkg::FLAG_BITS-1:0]      row_flags,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   row_counted,
    output logic      [fgc_pkg::OUT_BITS-1:0]       high_total,
    output logic      [fgc_pkg::OUT_BITS-1:0]       low_total
);
    import fgc_pkg::*;

    localparam int ROW_BITS = 2 * COUNT_BITS;

    logic [MASK_WORDS-1:0][MASK_BITS-1:0] group_mask_reg;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_func_reg;
    logic [GROUP_BITS-1:0] s1_group_reg;
    logic [PRIO_BIT:0]     s1_flags_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_counted_reg;
    logic [OUT_BITS-1:0]   out_high_reg;
    logic [OUT_BITS-1:0]   out_low_reg;

    logic                  in_accept;
    logic                  s1_advance;
    logic [ROW_BITS-1:0]   cur_row;
    logic [COUNT_BITS-1:0] cur_high;
    logic [COUNT_BITS-1:0] cur_low;
    logic [COUNT_BITS-1:0] new_high;
    logic [COUNT_BITS-1:0] new_low;
    logic [OUT_BITS-1:0]   clip_high;
    logic [OUT_BITS-1:0]   clip_low;
    logic                  selected;
    logic                  pass;
    wr_ctl_t               wr_ctl;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_mask_reg <= '0;
        end
        else if (cfg_we)
        begin
            group_mask_reg[cfg_index] <= cfg_data;
        end
    end

    // Lookup stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg  <= func;
            s1_group_reg <= group_code;
            s1_flags_reg <= row_flags[PRIO_BIT:0];
        end
    end

    fgc_count_ram #(
        .ROW_BITS (ROW_BITS)
    ) u_count_ram (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (in_accept),
        .rd_addr     (group_code),
        .lookup_addr (s1_group_reg),
        .wr_ctl      (wr_ctl),
        .wr_data     ({new_high, new_low}),
        .cur_data    (cur_row)
    );

    // Update stage: filter, saturating increment, write back
    assign cur_high = cur_row[ROW_BITS-1:COUNT_BITS];
    assign cur_low  = cur_row[COUNT_BITS-1:0];
    assign selected = group_mask_reg[s1_group_reg[GROUP_BITS-1:MASK_IDX_BITS]]
                                    [s1_group_reg[MASK_IDX_BITS-1:0]];
    assign pass     = (s1_func_reg == FUNC_COUNT) && selected
                      && (s1_flags_reg[1:0] == PASS_BITS);

    always_comb
    begin
        new_high = cur_high;
        new_low  = cur_low;
        if (s1_flags_reg[PRIO_BIT])
        begin
            if (!(&cur_high))
            begin
                new_high = cur_high + COUNT_BITS'(1);
            end
        end
        else
        begin
            if (!(&cur_low))
            begin
                new_low = cur_low + COUNT_BITS'(1);
            end
        end
    end

    assign wr_ctl.en   = s1_advance && pass;
    assign wr_ctl.addr = s1_group_reg;

    if (COUNT_BITS > OUT_BITS)
    begin : g_clip
        assign clip_high = (|cur_high[COUNT_BITS-1:OUT_BITS]) ? '1 : cur_high[OUT_BITS-1:0];
        assign clip_low  = (|cur_low[COUNT_BITS-1:OUT_BITS])  ? '1 : cur_low[OUT_BITS-1:0];
    end
    else
    begin : g_ext
        assign clip_high = OUT_BITS'(cur_high);
        assign clip_low  = OUT_BITS'(cur_low);
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_counted_reg <= pass;
            out_high_reg    <= (s1_func_reg == FUNC_READ) ? clip_high : '0;
            out_low_reg     <= (s1_func_reg == FUNC_READ) ? clip_low : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_counted = out_counted_reg;
    assign high_total  = out_high_reg;
    assign low_total   = out_low_reg;

endmodule : filtered_group_count

`default_nettype wire

@@ design/fgc_count_ram.sv @@
// Counter store: one synchronous memory holding the high and low count of each group.
// Per-entry valid bits give the cleared state after reset; the latest write is forwarded.
// Depends on fgc_pkg.
`default_nettype none

module fgc_count_ram #(
    parameter int ROW_BITS = 80
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [fgc_pkg::GROUP_BITS-1:0] rd_addr,
    input  wire logic [fgc_pkg::GROUP_BITS-1:0] lookup_addr,
    input  wire fgc_pkg::wr_ctl_t              wr_ctl,
    input  wire logic [ROW_BITS-1:0]           wr_data,
    output logic      [ROW_BITS-1:0]           cur_data
);
    import fgc_pkg::*;

    logic [ROW_BITS-1:0]   mem [GROUPS];
    logic [GROUPS-1:0]     vld_reg;
    logic [ROW_BITS-1:0]   rd_data_reg;
    logic                  rd_vld_reg;
    logic                  fwd_vld_reg;
    logic [GROUP_BITS-1:0] fwd_addr_reg;
    logic [ROW_BITS-1:0]   fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_ctl.en)
        begin
            mem[wr_ctl.addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_ctl.en)
            begin
                vld_reg[wr_ctl.addr] <= 1'b1;
                fwd_vld_reg          <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Keep the most recent write; it is the live value of its entry
    always_ff @(posedge clk)
    begin
        if (wr_ctl.en)
        begin
            fwd_addr_reg <= wr_ctl.addr;
            fwd_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        if (fwd_vld_reg && (fwd_addr_reg == lookup_addr))
        begin
            cur_data = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_data = rd_data_reg;
        end
        else
        begin
            cur_data = '0;
        end
    end

endmodule : fgc_count_ram

`default_nettype wire

@@ design/fgc_checker.sv @@
// Port-level checks for the filtered group counter, bound to the top level.
// Depends on fgc_pkg and filtered_group_count.
`default_nettype none

module fgc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic                              row_counted,
    input wire logic [fgc_pkg::OUT_BITS-1:0]       high_total,
    input wire logic [fgc_pkg::OUT_BITS-1:0]       low_total
);
    import fgc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_counted)
            && $stable(high_total) && $stable(low_total))
        else $error("result changed while stalled");

    // With the output register empty, the pipeline must drain and take an item
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // A counted row never reports totals
    a_row_no_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_counted |-> (high_total == '0) && (low_total == '0))
        else $error("counted row carries totals");

    // No result appears unless an item was accepted earlier or the input was stalled
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 1)
            || $past(in_valid && in_ready, 1))
        else $error("result without an accepted item");

endmodule : fgc_checker

bind filtered_group_count fgc_checker u_fgc_checker (.*);

`default_nettype wire
